// ----- sv/resource_cache_aging_table_assert.svh -----
// assertion macros used by the table rtl
`ifndef RESOURCE_CACHE_AGING_TABLE_ASSERT_SVH
`define RESOURCE_CACHE_AGING_TABLE_ASSERT_SVH

// same-cycle implication
`define RCAT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rcat_pkg.sv -----
package rcat_pkg;

   // request kinds
   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_FLUSH  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_LOAD_FAIL = 3'd2;
   localparam logic [2:0] ST_NO_FREE   = 3'd3;
   localparam logic [2:0] ST_TICK_DONE = 3'd4;
   localparam logic [2:0] ST_FLUSHED   = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_AUTO_COLLECT = 2'd0;
   localparam logic [1:0] CSR_MAX_AGE      = 2'd1;
   localparam logic [1:0] CSR_ENTRY_LIMIT  = 2'd2;

   localparam logic        AUTO_COLLECT_RESET = 1'b1;
   localparam logic [23:0] MAX_AGE_RESET      = 24'd30720;
   localparam logic [4:0]  ENTRY_LIMIT_RESET  = 5'd16;

   // compare results of the shared age unit
   typedef struct packed {
      logic ge;   // sum at or above the aged threshold
      logic gt;   // sum above the best age so far
   } age_flags_type;

endpackage

// ----- sv/rcat_ram.sv -----
module rcat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rcat_age_unit.sv -----
module rcat_age_unit import rcat_pkg::*; #(
   parameter int AGE_BITS = 24
) (
   input  logic [AGE_BITS-1:0] op,
   input  logic [15:0]         addend,
   input  logic [AGE_BITS-1:0] thr,
   input  logic [AGE_BITS-1:0] best,
   output logic [AGE_BITS-1:0] sum,
   output age_flags_type       flags
);

   localparam int SW = (AGE_BITS > 16 ? AGE_BITS : 16) + 1;

   logic [SW-1:0] raw;
   logic          sat;

   always_comb begin
      raw = SW'(op) + SW'(addend);
      sat = raw > SW'({AGE_BITS{1'b1}});
      sum = sat ? {AGE_BITS{1'b1}} : raw[AGE_BITS-1:0];
      flags.ge = sum >= thr;
      flags.gt = sum > best;
   end

endmodule

// ----- sv/resource_cache_aging_table.sv -----
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_type, key, load_ok, tick_delta
// rsp       out        rsp_valid / rsp_stall   status, hit, slot, evict, released
// csr       in         csr_write               csr_index, csr_wdata
//
// one item at a time; every pass walks the table one entry per cycle through the
// registered read port of the key and age memories and the shared age adder.
// lookup: a key scan; an insertion adds the age/victim pass and the eviction step,
// and then the result is emitted. tick and flush: a table pass, then emit; a tick
// with auto collection off goes straight to emit. all valid flags clear on reset.
// the result register lets the next item start while a result is still stalled.
`include "resource_cache_aging_table_assert.svh"

module resource_cache_aging_table import rcat_pkg::*; #(
   parameter int ENTRIES  = 32,
   parameter int AGE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key_high,
   input  logic [63:0] req_key_low,
   input  logic        req_load_ok,
   input  logic [15:0] req_tick_delta,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_hit,
   output logic [4:0]  rsp_slot,
   output logic        rsp_evict_valid,
   output logic [4:0]  rsp_evict_slot,
   output logic [31:0] rsp_released_mask,
   output logic [5:0]  rsp_released_count,

   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int TW = AGE_BITS > 24 ? AGE_BITS : 24;

   typedef enum logic [2:0] {
      S_IDLE, S_KEY, S_AGE, S_EVICT, S_TICK, S_FLUSH, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic                auto_ff, auto_in;
   logic [23:0]         max_age_ff, max_age_in;
   logic [4:0]          limit_ff, limit_in;

   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic                issue_done_ff, issue_done_in;
   logic                pv_ff, pv_in;
   logic [IW-1:0]       pidx_ff, pidx_in;

   logic [63:0]         kh_ff, kh_in;
   logic [63:0]         kl_ff, kl_in;
   logic                load_ok_ff, load_ok_in;
   logic [15:0]         delta_ff, delta_in;

   logic                free_found_ff, free_found_in;
   logic [IW-1:0]       free_ff, free_in;
   logic [CW-1:0]       live_ff, live_in;
   logic                vic_found_ff, vic_found_in;
   logic [IW-1:0]       vic_ff, vic_in;
   logic [AGE_BITS-1:0] best_ff, best_in;

   logic [2:0]          st_ff, st_in;
   logic                hit_ff, hit_in;
   logic [4:0]          slot_ff, slot_in;
   logic                ev_ff, ev_in;
   logic [4:0]          ev_slot_ff, ev_slot_in;
   logic [31:0]         mask_ff, mask_in;
   logic [6:0]          count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [4:0]          rsp_slot_ff, rsp_slot_in;
   logic                rsp_ev_ff, rsp_ev_in;
   logic [4:0]          rsp_ev_slot_ff, rsp_ev_slot_in;
   logic [31:0]         rsp_mask_ff, rsp_mask_in;
   logic [5:0]          rsp_count_ff, rsp_count_in;

   // memory ports
   logic                key_we;
   logic [IW-1:0]       key_waddr;
   logic [127:0]        key_rdata;
   logic                age_we;
   logic [IW-1:0]       age_waddr;
   logic [AGE_BITS-1:0] age_wdata;
   logic [AGE_BITS-1:0] age_rdata;

   // shared age unit
   logic [AGE_BITS-1:0] unit_op;
   logic [15:0]         unit_addend;
   logic [AGE_BITS-1:0] unit_sum;
   age_flags_type       unit_flags;

   logic [TW-1:0]       max_age_ext;
   logic [AGE_BITS-1:0] thr;
   logic                last;
   logic                vj;
   logic                is_new;
   logic                inc;
   logic                cand;
   logic                free_any;
   logic [IW-1:0]       free_sel;

   rcat_ram #(.WIDTH(128), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data ({kh_ff, kl_ff}),
      .rd_addr (cnt_ff),
      .rd_data (key_rdata)
   );

   rcat_ram #(.WIDTH(AGE_BITS), .DEPTH(ENTRIES)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_wdata),
      .rd_addr (cnt_ff),
      .rd_data (age_rdata)
   );

   rcat_age_unit #(.AGE_BITS(AGE_BITS)) u_age_unit (
      .op     (unit_op),
      .addend (unit_addend),
      .thr    (thr),
      .best   (best_ff),
      .sum    (unit_sum),
      .flags  (unit_flags)
   );

   // aged threshold: max_age clipped to the age range
   assign max_age_ext = TW'(max_age_ff);
   assign thr = (max_age_ext < TW'({AGE_BITS{1'b1}})) ? max_age_ext[AGE_BITS-1:0]
                                                       : {AGE_BITS{1'b1}};

   assign last   = pv_ff && (pidx_ff == IW'(ENTRIES - 1));
   assign vj     = valid_ff[pidx_ff];
   assign is_new = (pidx_ff == free_ff);
   assign inc    = !auto_ff && vj && !is_new;

   always_comb begin
      unit_op     = age_rdata;
      unit_addend = 16'd0;
      if (state_ff == S_TICK) begin
         unit_addend = delta_ff;
      end else if (state_ff == S_AGE) begin
         unit_op     = is_new ? '0 : age_rdata;
         unit_addend = {15'd0, inc};
      end
   end

   assign cand     = vj && (!auto_ff || !unit_flags.ge);
   assign free_any = free_found_ff || !vj;
   assign free_sel = free_found_ff ? free_ff : pidx_ff;

   always_comb begin
      state_in       = state_ff;
      auto_in        = auto_ff;
      max_age_in     = max_age_ff;
      limit_in       = limit_ff;
      valid_in       = valid_ff;
      cnt_in         = cnt_ff;
      issue_done_in  = issue_done_ff;
      pv_in          = 1'b0;
      pidx_in        = pidx_ff;
      kh_in          = kh_ff;
      kl_in          = kl_ff;
      load_ok_in     = load_ok_ff;
      delta_in       = delta_ff;
      free_found_in  = free_found_ff;
      free_in        = free_ff;
      live_in        = live_ff;
      vic_found_in   = vic_found_ff;
      vic_in         = vic_ff;
      best_in        = best_ff;
      st_in          = st_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      ev_in          = ev_ff;
      ev_slot_in     = ev_slot_ff;
      mask_in        = mask_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_ev_slot_in = rsp_ev_slot_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_count_in   = rsp_count_ff;
      key_we         = 1'b0;
      key_waddr      = free_sel;
      age_we         = 1'b0;
      age_waddr      = pidx_ff;
      age_wdata      = unit_sum;

      if (csr_write) begin
         unique case (csr_index)
            CSR_AUTO_COLLECT: auto_in    = csr_wdata[0];
            CSR_MAX_AGE:      max_age_in = csr_wdata;
            CSR_ENTRY_LIMIT:  limit_in   = csr_wdata[4:0];
            default: ;
         endcase
      end

      // one read issued per cycle in the scan states
      if ((state_ff == S_KEY || state_ff == S_AGE || state_ff == S_TICK ||
           state_ff == S_FLUSH) && !issue_done_ff) begin
         pv_in         = 1'b1;
         pidx_in       = cnt_ff;
         cnt_in        = cnt_ff + IW'(1);
         issue_done_in = (cnt_ff == IW'(ENTRIES - 1));
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kh_in         = req_key_high;
               kl_in         = req_key_low;
               load_ok_in    = req_load_ok;
               delta_in      = req_tick_delta;
               hit_in        = 1'b0;
               slot_in       = '0;
               ev_in         = 1'b0;
               ev_slot_in    = '0;
               mask_in       = '0;
               count_in      = '0;
               cnt_in        = '0;
               issue_done_in = 1'b0;
               free_found_in = 1'b0;
               st_in         = ST_TICK_DONE;
               unique case (req_type)
                  REQ_LOOKUP: state_in = S_KEY;
                  REQ_TICK:   state_in = auto_ff ? S_TICK : S_EMIT;
                  REQ_FLUSH: begin
                     st_in    = ST_FLUSHED;
                     state_in = S_FLUSH;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end

         S_KEY: begin
            if (pv_ff) begin
               if (vj && key_rdata == {kh_ff, kl_ff}) begin
                  st_in    = ST_HIT;
                  hit_in   = 1'b1;
                  slot_in  = 5'(pidx_ff);
                  age_we   = auto_ff;
                  age_wdata = '0;
                  state_in = S_EMIT;
               end else begin
                  if (!vj && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_in       = pidx_ff;
                  end
                  if (last) begin
                     if (!load_ok_ff) begin
                        st_in    = ST_LOAD_FAIL;
                        state_in = S_EMIT;
                     end else if (!free_any) begin
                        st_in    = ST_NO_FREE;
                        state_in = S_EMIT;
                     end else begin
                        // claim the slot, then walk the ages
                        st_in              = ST_INSERTED;
                        slot_in            = 5'(free_sel);
                        key_we             = 1'b1;
                        age_we             = 1'b1;
                        age_waddr          = free_sel;
                        age_wdata          = '0;
                        valid_in[free_sel] = 1'b1;
                        free_in            = free_sel;
                        cnt_in             = '0;
                        issue_done_in      = 1'b0;
                        live_in            = '0;
                        vic_found_in       = 1'b0;
                        best_in            = '0;
                        state_in           = S_AGE;
                     end
                  end
               end
            end
         end

         S_AGE: begin
            if (pv_ff) begin
               age_we = inc;
               if (cand) begin
                  live_in = live_ff + CW'(1);
                  if (!vic_found_ff || unit_flags.gt) begin
                     vic_found_in = 1'b1;
                     vic_in       = pidx_ff;
                     best_in      = unit_sum;
                  end
               end
               if (last) begin
                  state_in = S_EVICT;
               end
            end
         end

         S_EVICT: begin
            if ((8'(live_ff) > 8'(limit_ff)) && vic_found_ff) begin
               ev_in      = 1'b1;
               ev_slot_in = 5'(vic_ff);
               if (auto_ff) begin
                  age_we    = 1'b1;
                  age_waddr = vic_ff;
                  age_wdata = thr;
               end else begin
                  valid_in[vic_ff] = 1'b0;
               end
            end
            state_in = S_EMIT;
         end

         S_TICK, S_FLUSH: begin
            if (pv_ff) begin
               age_we = (state_ff == S_TICK) && vj;
               if (vj && (state_ff == S_FLUSH || unit_flags.ge)) begin
                  valid_in[pidx_ff] = 1'b0;
                  count_in          = count_ff + 7'd1;
                  if (7'(pidx_ff) < 7'd32) begin
                     mask_in[5'(pidx_ff)] = 1'b1;
                  end
               end
               if (last) begin
                  state_in = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = st_ff;
               rsp_hit_in     = hit_ff;
               rsp_slot_in    = slot_ff;
               rsp_ev_in      = ev_ff;
               rsp_ev_slot_in = ev_slot_ff;
               rsp_mask_in    = mask_ff;
               rsp_count_in   = count_ff[5:0];
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         auto_ff       <= AUTO_COLLECT_RESET;
         max_age_ff    <= MAX_AGE_RESET;
         limit_ff      <= ENTRY_LIMIT_RESET;
         valid_ff      <= '0;
         issue_done_ff <= 1'b1;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         auto_ff       <= auto_in;
         max_age_ff    <= max_age_in;
         limit_ff      <= limit_in;
         valid_ff      <= valid_in;
         issue_done_ff <= issue_done_in;
         pv_ff         <= pv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cnt_ff         <= cnt_in;
      pidx_ff        <= pidx_in;
      kh_ff          <= kh_in;
      kl_ff          <= kl_in;
      load_ok_ff     <= load_ok_in;
      delta_ff       <= delta_in;
      free_found_ff  <= free_found_in;
      free_ff        <= free_in;
      live_ff        <= live_in;
      vic_found_ff   <= vic_found_in;
      vic_ff         <= vic_in;
      best_ff        <= best_in;
      st_ff          <= st_in;
      hit_ff         <= hit_in;
      slot_ff        <= slot_in;
      ev_ff          <= ev_in;
      ev_slot_ff     <= ev_slot_in;
      mask_ff        <= mask_in;
      count_ff       <= count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_ev_slot_ff <= rsp_ev_slot_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_evict_valid    = rsp_ev_ff;
   assign rsp_evict_slot     = rsp_ev_slot_ff;
   assign rsp_released_mask  = rsp_mask_ff;
   assign rsp_released_count = rsp_count_ff;

   `RCAT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
      req_stall, "item accepted but block not busy next cycle")
   `RCAT_ASSERT_IMPLY(a_hit_status, clock, reset, rsp_valid && rsp_hit,
      rsp_status == ST_HIT, "hit flag without hit status")
   `RCAT_ASSERT_IMPLY(a_evict_on_insert, clock, reset, rsp_valid && rsp_evict_valid,
      rsp_status == ST_INSERTED, "eviction reported without insertion")
   `RCAT_ASSERT_IMPLY(a_release_kind, clock, reset,
      rsp_valid && (rsp_released_count != 6'd0),
      (rsp_status == ST_TICK_DONE) || (rsp_status == ST_FLUSHED),
      "entries released outside tick or flush")
   `RCAT_ASSERT_IMPLY(a_release_count, clock, reset, rsp_valid,
      (ENTRIES > 32) || ($countones(rsp_released_mask) == int'(rsp_released_count)),
      "released count differs from mask")

endmodule
